### rtl/lap3_pkg.sv
package lap3_pkg;

	// field widths
	localparam int PIX_W = 8;
	localparam int COL_W = 11;
	localparam int ROW_W = 12;
	localparam int FRM_W = 11;
	localparam int CFG_W = 12;

	// window and clamp constants
	localparam int WIN_SIZE     = 3;
	localparam int CENTER_SHIFT = 3;      // centre weight -8
	localparam int PIX_MAX      = 255;
	localparam int MAX_FRAMES   = 2048;

	// sum of eight neighbours needs 11 bits, signed difference 13
	localparam int NSUM_W = PIX_W + 3;
	localparam int DIFF_W = NSUM_W + 2;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_FRAMES = 2'd2
	} cfg_reg_t;

	// reset values of the configuration registers
	localparam logic [CFG_W-1:0] RST_WIDTH  = 12'd2048;
	localparam logic [CFG_W-1:0] RST_HEIGHT = 12'd3;
	localparam logic [CFG_W-1:0] RST_FRAMES = 12'd1;

endpackage

### rtl/laplacian_3x3_convolution_core.sv
// 3x3 Laplacian filter for a raster stream of 8-bit grayscale pixels.
//
// Input channel (in_valid/in_ready, pixel_in): one pixel per item, frames of
// image_width x image_height pixels back to back, frames_in_batch per batch.
// Output channel (out_valid/out_ready): one item per interior pixel with the
// clamped Laplacian, its column and row, and end-of-frame / end-of-batch
// flags. Border pixels give no output item.
// Configuration: cfg_wr_en writes cfg_data into the register cfg_index
// (0 width, 1 height, 2 frames per batch); write only while the block is idle.
//
// Throughput is one pixel per cycle while the output is not stalled: each line
// store has one read and one write port, and the 3x3 sum fits between the input
// stage and the output register. Each result passes through the input stage and
// then the output register; out_valid rises as the item leaves the input stage.
// When out_ready is low the result waits in the output register; one more
// pixel can be taken into the input stage, then in_ready drops.
// Reset clears the counters, the window and the valid flags and restores the
// default configuration; line store contents are undefined until written.
module laplacian_3x3_convolution_core #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [1:0]                    cfg_index,
	input  logic [lap3_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lap3_pkg::PIX_W-1:0]    pixel_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lap3_pkg::PIX_W-1:0]    pixel_out,
	output logic [lap3_pkg::COL_W-1:0]    out_col,
	output logic [lap3_pkg::ROW_W-1:0]    out_row,
	output logic                          end_of_frame,
	output logic                          end_of_batch
);
	import lap3_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WX = ((CW > CFG_W) ? CW : CFG_W) + 1;

	// configuration registers
	logic [CFG_W-1:0] width_q, height_q, frames_q;

	// counters
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [FRM_W-1:0] frame_q;

	// input stage
	logic             v_s1;
	logic [PIX_W-1:0] pix_s1, up_s1, mid_s1;
	logic [CW-1:0]    col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             emit_s1, eof_s1, eob_s1;

	// line stores and window
	logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
	logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
	logic [PIX_W-1:0] win_q [6];

	logic             accept, adv_s1;
	logic [WX-1:0]    width_x;
	logic [CW-1:0]    w_m1;
	logic [ROW_W-1:0] h_m1;
	logic [FRM_W-1:0] f_m1;
	logic             last_col, last_row, last_frame;
	logic [NSUM_W-1:0] nsum;
	logic [DIFF_W-1:0] diff;
	logic [PIX_W-1:0]  clamped;
	logic [CW-1:0]     col_m1;
	logic [CW+COL_W-1:0] col_m1_x;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			frames_q <= RST_FRAMES;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_FRAMES: frames_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective limits, minus one
	always_comb begin
		width_x = WX'(width_q);
		if (width_x < WX'(WIN_SIZE))
			w_m1 = CW'(WIN_SIZE - 1);
		else if (width_x > WX'(MAX_WIDTH))
			w_m1 = CW'(MAX_WIDTH - 1);
		else
			w_m1 = CW'(width_x - WX'(1));

		if (height_q < CFG_W'(WIN_SIZE))
			h_m1 = ROW_W'(WIN_SIZE - 1);
		else
			h_m1 = height_q - ROW_W'(1);

		if (frames_q == '0)
			f_m1 = '0;
		else if (frames_q > CFG_W'(MAX_FRAMES))
			f_m1 = FRM_W'(MAX_FRAMES - 1);
		else
			f_m1 = FRM_W'(frames_q - CFG_W'(1));
	end

	assign last_col   = (col_q >= w_m1);
	assign last_row   = (row_q >= h_m1);
	assign last_frame = (frame_q >= f_m1);

	// handshake
	assign adv_s1   = v_s1 && (!out_valid || out_ready);
	assign in_ready = !v_s1 || adv_s1;
	assign accept   = in_valid && in_ready;

	// raster counters, advanced on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			frame_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q   <= '0;
					frame_q <= last_frame ? '0 : frame_q + FRM_W'(1);
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (in_ready)
			v_s1 <= in_valid;
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pixel_in;
			col_s1  <= col_q;
			row_s1  <= row_q;
			emit_s1 <= (col_q >= CW'(2)) && (row_q >= ROW_W'(2));
			eof_s1  <= last_col && last_row;
			eob_s1  <= last_col && last_row && last_frame;
		end
	end

	// line store read, registered alongside the input stage
	always_ff @(posedge clk) begin
		if (accept) begin
			up_s1  <= upper_mem[col_q];
			mid_s1 <= middle_mem[col_q];
		end
	end

	// line store write as the item leaves the input stage
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			upper_mem[col_s1]  <= mid_s1;
			middle_mem[col_s1] <= pix_s1;
		end
	end

	// window shift: column x-1 moves to x-2, new column enters at x-1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++)
				win_q[i] <= '0;
		end else if (adv_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= up_s1;
			win_q[4] <= mid_s1;
			win_q[5] <= pix_s1;
		end
	end

	// Laplacian sum and clamp
	always_comb begin
		nsum = NSUM_W'(win_q[0]) + NSUM_W'(win_q[1]) + NSUM_W'(win_q[2])
		     + NSUM_W'(win_q[3]) + NSUM_W'(win_q[5])
		     + NSUM_W'(up_s1) + NSUM_W'(mid_s1) + NSUM_W'(pix_s1);
		diff = DIFF_W'(nsum) - (DIFF_W'(win_q[4]) << CENTER_SHIFT);
		if (diff[DIFF_W-1])
			clamped = '0;
		else if (diff[DIFF_W-2:PIX_W] != '0)
			clamped = PIX_W'(PIX_MAX);
		else
			clamped = diff[PIX_W-1:0];
	end

	assign col_m1   = col_s1 - CW'(1);
	assign col_m1_x = (CW+COL_W)'(col_m1);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (adv_s1)
			out_valid <= emit_s1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			pixel_out    <= clamped;
			out_col      <= col_m1_x[COL_W-1:0];
			out_row      <= row_s1 - ROW_W'(1);
			end_of_frame <= eof_s1;
			end_of_batch <= eob_s1;
		end
	end

endmodule

### rtl/lap3_checker.sv
module lap3_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [lap3_pkg::PIX_W-1:0]    pixel_out,
	input logic [lap3_pkg::COL_W-1:0]    out_col,
	input logic [lap3_pkg::ROW_W-1:0]    out_row,
	input logic                          end_of_frame,
	input logic                          end_of_batch
);
	import lap3_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_out)
		&& $stable(out_col) && $stable(out_row)
		&& $stable(end_of_frame) && $stable(end_of_batch))
		else $error("output item changed while stalled");

	// a new result appears only after its input item was taken into the input stage
	a_out_from_in: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("output item without a preceding input item");

	// end of batch is always also end of frame
	a_eob_eof: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_batch |-> end_of_frame)
		else $error("end_of_batch without end_of_frame");

	// border pixels are never emitted: no item has column 0 or row 0
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_col != '0) && (out_row != '0))
		else $error("border pixel emitted");

endmodule

bind laplacian_3x3_convolution_core lap3_checker u_lap3_checker (.*);

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import lap3_pkg::*;

	localparam int LINE_MAX     = 2048;
	localparam int RANDOM_ITEMS = 620;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 150;
	localparam int QUIET_LIMIT  = 4000;
	localparam int PRINT_MAX    = 30;

	// one filtered pixel as the block reports it
	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             eof;
		logic             eob;
	} lap_result_t;

	// directed batch: register values, write mask, 3x3 frame of ring and center, expected result
	typedef struct packed {
		logic [2:0]       mask;
		logic [CFG_W-1:0] w;
		logic [CFG_W-1:0] h;
		logic [CFG_W-1:0] f;
		logic [PIX_W-1:0] ring;
		logic [PIX_W-1:0] center;
		logic [PIX_W-1:0] want;
	} dir_row_t;

	localparam dir_row_t DIR_TAB [3] = '{
		// width only; height and frames keep their reset values
		'{3'b001, 12'd3, 12'd0, 12'd0, 8'd255, 8'd0, 8'd255},
		// zero in every register falls back to the minimum; dark ring floors at 0
		'{3'b111, 12'd0, 12'd0, 12'd0, 8'd0, 8'd255, 8'd0},
		// width 2 and height 1 also fall back; unclamped 96 - 80
		'{3'b111, 12'd2, 12'd1, 12'd1, 8'd12, 8'd10, 8'd16}
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [1:0]          cfg_index;
	logic [CFG_W-1:0]    cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [PIX_W-1:0]    pixel_in;
	logic                out_valid;
	logic                out_ready;
	logic [PIX_W-1:0]    pixel_out;
	logic [COL_W-1:0]    out_col;
	logic [ROW_W-1:0]    out_row;
	logic                end_of_frame;
	logic                end_of_batch;

	// predictor state
	logic [CFG_W-1:0]    width_reg, height_reg, frames_reg;
	logic [PIX_W-1:0]    upper_line [LINE_MAX];
	logic [PIX_W-1:0]    middle_line [LINE_MAX];
	logic [PIX_W-1:0]    win [6];
	int unsigned         col_cnt, row_cnt, frm_cnt;

	lap_result_t         filtered_q [$];
	int                  mismatches = 0;
	int                  results_seen = 0;
	int                  pixels_in = 0;
	int                  batches = 0;
	int                  burst_left = 0;
	int                  quiet_cycles = 0;
	int                  pix_base = 0;

	laplacian_3x3_convolution_core #(.MAX_WIDTH(LINE_MAX)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_in     (pixel_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_out    (pixel_out),
		.out_col      (out_col),
		.out_row      (out_row),
		.end_of_frame (end_of_frame),
		.end_of_batch (end_of_batch)
	);

	always #5 clk = ~clk;

	// effective geometry after clamping the registers
	function automatic int unsigned line_len();
		if (width_reg < WIN_SIZE) return WIN_SIZE;
		if (width_reg > LINE_MAX) return LINE_MAX;
		return width_reg;
	endfunction

	function automatic int unsigned frame_rows();
		return (height_reg < WIN_SIZE) ? WIN_SIZE : height_reg;
	endfunction

	function automatic int unsigned batch_frames();
		if (frames_reg < 1) return 1;
		if (frames_reg > MAX_FRAMES) return MAX_FRAMES;
		return frames_reg;
	endfunction

	function automatic int unsigned batch_pixels();
		return line_len() * frame_rows() * batch_frames();
	endfunction

	// advance the filter by one pixel; returns 1 when an interior pixel completes
	function automatic bit filter_pixel(input logic [PIX_W-1:0] cur, output lap_result_t res);
		int unsigned w, h, f, idx;
		logic [PIX_W-1:0] up, mid;
		bit lc, lr, lf, hit;
		int acc;
		w = line_len();
		h = frame_rows();
		f = batch_frames();
		idx = (col_cnt < LINE_MAX) ? col_cnt : 0;
		up = upper_line[idx];
		mid = middle_line[idx];
		lc = col_cnt >= w - 1;
		lr = row_cnt >= h - 1;
		lf = frm_cnt >= f - 1;
		hit = (col_cnt >= 2) && (row_cnt >= 2);
		res = '0;
		if (hit) begin
			acc = int'(up) + int'(mid) + int'(cur) - 8 * int'(win[4]);
			for (int i = 0; i < 6; i++)
				if (i != 4) acc += int'(win[i]);
			if (acc < 0) acc = 0;
			if (acc > PIX_MAX) acc = PIX_MAX;
			res.pix = acc[PIX_W-1:0];
			res.col = COL_W'(col_cnt - 1);
			res.row = ROW_W'(row_cnt - 1);
			res.eof = lc && lr;
			res.eob = lc && lr && lf;
		end
		// window moves one column right
		win[0] = win[3];
		win[1] = win[4];
		win[2] = win[5];
		win[3] = up;
		win[4] = mid;
		win[5] = cur;
		upper_line[idx] = mid;
		middle_line[idx] = cur;
		// raster counters
		if (lc) begin
			col_cnt = 0;
			if (lr) begin
				row_cnt = 0;
				frm_cnt = lf ? 0 : frm_cnt + 1;
			end else begin
				row_cnt++;
			end
		end else begin
			col_cnt++;
		end
		return hit;
	endfunction

	function automatic logic [PIX_W-1:0] gen_pixel(input int mode);
		case (mode)
			1: return PIX_W'(pix_base + $urandom_range(0, 6));   // smooth area
			2: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
			3: return PIX_W'($urandom_range(0, 3));
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		mismatches++;
		if (mismatches <= PRINT_MAX)
			$display("mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
	endtask

	// offer one pixel in bursts with random gaps; predict on accept
	task automatic send_pixel(input logic [PIX_W-1:0] px, input bit typed,
			input logic [PIX_W-1:0] want);
		int gap;
		lap_result_t res;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		pixel_in <= px;
		do @(posedge clk); while (!in_ready);
		pixels_in++;
		if (filter_pixel(px, res)) begin
			if (typed)
				res.pix = want;
			filtered_q.insert(filtered_q.size(), res);
		end
	endtask

	// stop offering and let every pending item come out
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (filtered_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_WIDTH:  width_reg = val;
			REG_HEIGHT: height_reg = val;
			REG_FRAMES: frames_reg = val;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [2:0] mask, input logic [CFG_W-1:0] w, h, f);
		if (mask[0]) write_reg(REG_WIDTH, w);
		if (mask[1]) write_reg(REG_HEIGHT, h);
		if (mask[2]) write_reg(REG_FRAMES, f);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// one complete batch of generated pixels under a new setting
	task automatic run_batch(input logic [CFG_W-1:0] w, h, f, input int mode);
		int unsigned n;
		wait_drained();
		set_config(3'b111, w, h, f);
		pix_base = $urandom_range(0, 249);
		n = batch_pixels();
		repeat (n) send_pixel(gen_pixel(mode), 1'b0, '0);
		batches++;
	endtask

	// output checker
	always @(posedge clk) begin
		lap_result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (filtered_q.size() == 0) begin
				report_mismatch("item with none pending", pixel_out, 0);
			end else begin
				want = filtered_q.pop_front();
				if (pixel_out !== want.pix) report_mismatch("pixel_out", pixel_out, want.pix);
				if (out_col !== want.col) report_mismatch("out_col", out_col, want.col);
				if (out_row !== want.row) report_mismatch("out_row", out_row, want.row);
				if (end_of_frame !== want.eof)
					report_mismatch("end_of_frame", end_of_frame, want.eof);
				if (end_of_batch !== want.eob)
					report_mismatch("end_of_batch", end_of_batch, want.eob);
			end
		end
	end

	// watchdog on cycles where no item moves
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver: stall patterns in spans, plus one long hold while the sender offers
	initial begin
		int mode;
		int span_left;
		bit held;
		logic [31:0] stall_pat;
		out_ready = 1'b0;
		span_left = 0;
		held = 0;
		mode = 0;
		stall_pat = '0;
		forever begin
			@(negedge clk);
			if (!held && in_valid && pixels_in >= HOLD_AFTER) begin
				held = 1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				if (span_left == 0) begin
					mode = $urandom_range(0, 3);
					span_left = $urandom_range(16, 128);
					stall_pat = $urandom;
				end
				span_left--;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= stall_pat[span_left % 32];
					default: out_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// stimulus
	initial begin
		int unsigned random_px;
		int unsigned n;
		logic [CFG_W-1:0] w, h, f;
		int mode;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		pixel_in = '0;
		width_reg = RST_WIDTH;
		height_reg = RST_HEIGHT;
		frames_reg = RST_FRAMES;
		for (int i = 0; i < LINE_MAX; i++) begin
			upper_line[i] = '0;
			middle_line[i] = '0;
		end
		for (int i = 0; i < 6; i++)
			win[i] = '0;
		col_cnt = 0;
		row_cnt = 0;
		frm_cnt = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed 3x3 frames, one interior pixel each
		for (int r = 0; r < 3; r++) begin
			wait_drained();
			set_config(DIR_TAB[r].mask, DIR_TAB[r].w, DIR_TAB[r].h, DIR_TAB[r].f);
			for (int p = 0; p < 9; p++)
				send_pixel((p == 4) ? DIR_TAB[r].center : DIR_TAB[r].ring, p == 8, DIR_TAB[r].want);
			batches++;
		end

		// registers rewritten mid-frame: column and row counters beyond the new limits
		wait_drained();
		set_config(3'b111, 12'd6, 12'd5, 12'd3);
		repeat (22) send_pixel(gen_pixel(0), 1'b0, '0);
		wait_drained();
		set_config(3'b111, 12'd3, 12'd3, 12'd1);
		send_pixel(gen_pixel(0), 1'b0, '0);
		batches++;

		// random batches, mostly small, with occasional out-of-range registers
		random_px = 0;
		while (random_px < RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0)
				w = CFG_W'($urandom_range(17, 48));
			else
				w = CFG_W'($urandom_range(3, 16));
			h = CFG_W'($urandom_range(3, 6));
			f = CFG_W'($urandom_range(1, 2));
			if ($urandom_range(0, 15) == 0) w = CFG_W'($urandom_range(0, 2));
			if ($urandom_range(0, 15) == 0) h = CFG_W'($urandom_range(0, 2));
			if ($urandom_range(0, 15) == 0) f = '0;
			mode = $urandom_range(0, 3);
			run_batch(w, h, f, mode);
			n = batch_pixels();
			random_px += n;
		end

		wait_drained();
		repeat (8) @(posedge clk);
		$display("%0d pixels in %0d batches, %0d filtered items checked", pixels_in, batches,
			results_seen);
		$display("small frames, clamped registers, a mid-frame rewrite, one %0d-cycle hold",
			HOLD_CYCLES);
		if (mismatches == 0 && filtered_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			if (filtered_q.size() != 0)
				$display("%0d filtered items never arrived", filtered_q.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### sim.f
rtl/lap3_pkg.sv
rtl/laplacian_3x3_convolution_core.sv
rtl/lap3_checker.sv
tb/testbench.sv
